### rtl/configurable_crc_engine_defines.svh
// Assertion macros for the configurable CRC engine.
// Expects clk and rst_n in the scope of each use; empty under SYNTHESIS.
`ifndef CONFIGURABLE_CRC_ENGINE_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define CRCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CRCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRCE_ASSERT(label, prop, msg)
`define CRCE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/crce_pkg.sv
// Shared types, codes and bit helpers for the configurable CRC engine.
// No dependencies; used by the channel interfaces and all modules.
package crce_pkg;

    localparam int unsigned CRC_BITS  = 32;
    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned WIDTH_BITS = 6;
    localparam int unsigned CFG_INDEX_BITS = 3;

    typedef logic [CRC_BITS-1:0]       crc_word_t;
    typedef logic [BYTE_BITS-1:0]      crc_byte_t;
    typedef logic [WIDTH_BITS-1:0]     crc_width_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // register indexes on the configuration channel
    localparam cfg_index_t CFG_INITIAL_VALUE  = 3'd0;
    localparam cfg_index_t CFG_POLYNOMIAL     = 3'd1;
    localparam cfg_index_t CFG_CRC_WIDTH      = 3'd2;
    localparam cfg_index_t CFG_REFLECT_INPUT  = 3'd3;
    localparam cfg_index_t CFG_REFLECT_OUTPUT = 3'd4;

    // supported CRC widths
    localparam crc_width_t WIDTH_7  = 6'd7;
    localparam crc_width_t WIDTH_8  = 6'd8;
    localparam crc_width_t WIDTH_16 = 6'd16;
    localparam crc_width_t WIDTH_32 = 6'd32;

    localparam crc_word_t MASK_7  = 32'h0000_007F;
    localparam crc_word_t MASK_8  = 32'h0000_00FF;
    localparam crc_word_t MASK_16 = 32'h0000_FFFF;
    localparam crc_word_t MASK_32 = 32'hFFFF_FFFF;

    // reset values of the registers
    localparam crc_word_t  RESET_INITIAL_VALUE = 32'h0000_0000;
    localparam crc_word_t  RESET_POLYNOMIAL    = 32'h0000_1021;
    localparam crc_width_t RESET_CRC_WIDTH     = WIDTH_16;

    typedef struct packed {
        crc_word_t  initial_value;
        crc_word_t  polynomial;
        crc_width_t crc_width;
        logic       reflect_input;
        logic       reflect_output;
    } crce_cfg_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

endpackage

### rtl/crce_if.sv
// Valid/ready channel interfaces of the configurable CRC engine:
// byte input, result output and register write. Depends on crce_pkg.
interface crce_in_if;
    logic                valid;
    logic                ready;
    crce_pkg::crc_byte_t data_byte;
    logic                first_byte;
    logic                last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface crce_out_if;
    logic                valid;
    logic                ready;
    crce_pkg::crc_word_t crc_result;

    modport source (output valid, crc_result, input ready);
    modport sink   (input valid, crc_result, output ready);
endinterface

interface crce_cfg_if;
    logic                 valid;
    logic                 ready;
    crce_pkg::cfg_index_t index;
    crce_pkg::crc_word_t  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/crce_update.sv
// Combinational byte fold: next running CRC and the result, its low 8 or 16 bits
// reflected when reflect_output is set and the width is 16 or less. Depends on crce_pkg.
module crce_update (
    input  crce_pkg::crce_cfg_t cfg,
    input  crce_pkg::crc_word_t crc_in,
    input  crce_pkg::crc_byte_t data_byte,
    input  logic                first_byte,
    output crce_pkg::crc_word_t crc_next,
    output crce_pkg::crc_word_t crc_result
);
    import crce_pkg::*;

    crc_word_t start;
    crc_byte_t byte_val;
    crc_word_t x0;
    crc_word_t mask;
    logic [4:0] top;
    logic       update;
    crc_word_t  folded;

    always_comb
    begin
        start    = first_byte ? cfg.initial_value : crc_in;
        byte_val = cfg.reflect_input ? rev8(data_byte) : data_byte;
        unique case (cfg.crc_width)
            WIDTH_7:
            begin
                x0 = start ^ {24'b0, byte_val};
                top = 5'd6;
                mask = MASK_7;
                update = 1'b1;
            end
            WIDTH_8:
            begin
                x0 = start ^ {24'b0, byte_val};
                top = 5'd7;
                mask = MASK_8;
                update = 1'b1;
            end
            WIDTH_16:
            begin
                x0 = start ^ {16'b0, byte_val, 8'b0};
                top = 5'd15;
                mask = MASK_16;
                update = 1'b1;
            end
            WIDTH_32:
            begin
                x0 = start ^ {byte_val, 24'b0};
                top = 5'd31;
                mask = MASK_32;
                update = 1'b1;
            end
            default:
            begin
                x0 = start;
                top = 5'd31;
                mask = MASK_32;
                update = 1'b0;
            end
        endcase
    end

    // eight MSB-first shift steps; feedback bit picked by width
    always_comb
    begin
        folded = x0;
        for (int i = 0; i < BYTE_BITS; i++) begin
            if (folded[top]) begin
                folded = {folded[CRC_BITS-2:0], 1'b0} ^ cfg.polynomial;
            end else begin
                folded = {folded[CRC_BITS-2:0], 1'b0};
            end
        end
    end

    assign crc_next = update ? (folded & mask) : start;

    always_comb
    begin
        priority if (cfg.reflect_output && cfg.crc_width <= WIDTH_8) begin
            crc_result = {24'b0, rev8(crc_next[7:0])};
        end else if (cfg.reflect_output && cfg.crc_width <= WIDTH_16) begin
            crc_result = {16'b0, rev16(crc_next[15:0])};
        end else begin
            crc_result = crc_next;
        end
    end

endmodule

### rtl/configurable_crc_engine.sv
// Top level of the configurable CRC engine: registers, running CRC, result stage.
// Depends on crce_pkg, crce_if, crce_update and configurable_crc_engine_defines.svh.
//
// Usage:
//   data_in  - one message byte per item with first_byte / last_byte marks.
//              first_byte loads initial_value before the byte is folded.
//   crc_out  - one crc_result item per byte marked last_byte.
//   cfg      - register writes (index 0..4: initial_value, polynomial,
//              crc_width, reflect_input, reflect_output); always ready,
//              indexes above 4 are dropped. Write only while idle.
// Throughput: one byte per cycle unless stalled; the whole eight-step fold of a byte
//   is done in the cycle it is accepted, straight into the running CRC register.
// Result: the result of a last byte is valid in the cycle after it is accepted,
//   held in a single output register.
// Stall: while the output register holds a result not yet taken, bytes are
//   still accepted if crc_out.ready is high; with crc_out.ready low, bytes
//   are held off, since the next last byte could not be stored.
// Reset: registers return to polynomial 0x1021, width 16, no reflection,
//   initial value 0; running CRC clears to 0 and no result is pending.
`include "configurable_crc_engine_defines.svh"

module configurable_crc_engine (
    input  logic clk,
    input  logic rst_n,
    crce_in_if.sink    data_in,
    crce_out_if.source crc_out,
    crce_cfg_if.sink   cfg
);
    import crce_pkg::*;

    crce_cfg_t cfg_reg;
    crc_word_t running_crc_reg;
    crc_word_t result_reg;
    logic      out_valid_reg;
    logic      out_valid_next;

    crc_word_t crc_next;
    crc_word_t crc_result;
    logic      accept;
    logic      cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.initial_value  <= RESET_INITIAL_VALUE;
            cfg_reg.polynomial     <= RESET_POLYNOMIAL;
            cfg_reg.crc_width      <= RESET_CRC_WIDTH;
            cfg_reg.reflect_input  <= 1'b0;
            cfg_reg.reflect_output <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg.index)
                CFG_INITIAL_VALUE:  cfg_reg.initial_value  <= cfg.data;
                CFG_POLYNOMIAL:     cfg_reg.polynomial     <= cfg.data;
                CFG_CRC_WIDTH:      cfg_reg.crc_width      <= cfg.data[WIDTH_BITS-1:0];
                CFG_REFLECT_INPUT:  cfg_reg.reflect_input  <= cfg.data[0];
                CFG_REFLECT_OUTPUT: cfg_reg.reflect_output <= cfg.data[0];
                default:            ;
            endcase
        end
    end

    crce_update u_update (
        .cfg        (cfg_reg),
        .crc_in     (running_crc_reg),
        .data_byte  (data_in.data_byte),
        .first_byte (data_in.first_byte),
        .crc_next   (crc_next),
        .crc_result (crc_result)
    );

    assign data_in.ready = !out_valid_reg || crc_out.ready;
    assign accept        = data_in.valid && data_in.ready;

    always_comb
    begin
        priority if (accept && data_in.last_byte) begin
            out_valid_next = 1'b1;
        end else if (crc_out.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            running_crc_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                running_crc_reg <= crc_next;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept && data_in.last_byte) begin
            result_reg <= crc_result;
        end
    end

    assign crc_out.valid      = out_valid_reg;
    assign crc_out.crc_result = result_reg;

    `CRCE_ASSERT_NEXT(a_last_gives_result, accept && data_in.last_byte, out_valid_reg,
        "last byte accepted but no result pending")
    `CRCE_ASSERT(a_ready_only_on_stall,
        !data_in.ready |-> (out_valid_reg && !crc_out.ready),
        "input held off without a stalled result")
    `CRCE_ASSERT_NEXT(a_mid_byte_keeps_out,
        accept && !data_in.last_byte && !(crc_out.valid && crc_out.ready),
        $stable(out_valid_reg), "result valid changed on a byte that is not last")
    `CRCE_ASSERT_NEXT(a_width8_masked, accept && cfg_reg.crc_width == WIDTH_8,
        running_crc_reg[CRC_BITS-1:BYTE_BITS] == '0, "8-bit CRC has upper bits set")

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for configurable_crc_engine: directed and random byte streams under
// many register settings, each crc_result compared against a built-in CRC predictor.
// Depends on crce_pkg, the crce_in_if / crce_out_if / crce_cfg_if interfaces and the engine RTL.
module testbench;
    import crce_pkg::*;

    localparam int unsigned CYCLE_LIMIT       = 600000;
    localparam int unsigned DRAIN_CYCLES      = 8;
    localparam int unsigned BYTES_PER_SETTING = 90;
    localparam int unsigned RANDOM_SETTINGS   = 13;
    localparam cfg_index_t  FIRST_UNMAPPED    = CFG_REFLECT_OUTPUT + 3'd1;
    localparam cfg_index_t  LAST_UNMAPPED     = '1;

    logic clk = 1'b0;
    logic rst_n;

    crce_in_if  in_ch();
    crce_out_if out_ch();
    crce_cfg_if cfg_ch();

    configurable_crc_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .data_in (in_ch),
        .crc_out (out_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the registers and the running CRC
    crc_word_t  init_q;
    crc_word_t  poly_q;
    crc_width_t width_q;
    logic       refl_in_q;
    logic       refl_out_q;
    crc_word_t  running_q;
    crc_word_t  crc_queue[$];

    int unsigned error_count   = 0;
    int unsigned bytes_in      = 0;
    int unsigned results_out   = 0;
    int unsigned settings_done = 0;
    int unsigned cycle_count   = 0;
    bit          gaps_on       = 1'b1;

    task automatic report(input string what);
        error_count++;
        $display("[%0t] ERROR: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : predict_and_check
        crc_byte_t   b;
        crc_word_t   c;
        crc_word_t   mask;
        crc_word_t   top;
        crc_word_t   want;
        logic [7:0]  lo8;
        logic [15:0] lo16;
        int unsigned lane;
        logic        supported;

        cycle_count++;
        if (!rst_n)
        begin
            init_q     = RESET_INITIAL_VALUE;
            poly_q     = RESET_POLYNOMIAL;
            width_q    = RESET_CRC_WIDTH;
            refl_in_q  = 1'b0;
            refl_out_q = 1'b0;
            running_q  = '0;
            crc_queue.delete();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_INITIAL_VALUE:  init_q     = cfg_ch.data;
                    CFG_POLYNOMIAL:     poly_q     = cfg_ch.data;
                    CFG_CRC_WIDTH:      width_q    = cfg_ch.data[WIDTH_BITS-1:0];
                    CFG_REFLECT_INPUT:  refl_in_q  = cfg_ch.data[0];
                    CFG_REFLECT_OUTPUT: refl_out_q = cfg_ch.data[0];
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                bytes_in++;
                if (in_ch.first_byte)
                    running_q = init_q;
                b = in_ch.data_byte;
                if (refl_in_q)
                    b = {<<{in_ch.data_byte}};

                supported = 1'b1;
                mask      = MASK_32;
                case (width_q)
                    WIDTH_7:  mask = MASK_7;
                    WIDTH_8:  mask = MASK_8;
                    WIDTH_16: mask = MASK_16;
                    WIDTH_32: mask = MASK_32;
                    default:  supported = 1'b0;
                endcase
                // tested bit is the top bit of the mask; wide CRCs take the byte at the top
                top  = mask ^ (mask >> 1);
                lane = (width_q > WIDTH_8) ? width_q - WIDTH_8 : 0;
                if (supported)
                begin
                    c = running_q ^ (crc_word_t'(b) << lane);
                    for (int i = 0; i < 8; i++)
                        c = ((c & top) != '0) ? ((c << 1) ^ poly_q) : (c << 1);
                    running_q = c & mask;
                end

                if (in_ch.last_byte)
                begin
                    want = running_q;
                    if (refl_out_q && width_q <= WIDTH_8)
                    begin
                        lo8  = {<<{running_q[7:0]}};
                        want = crc_word_t'(lo8);
                    end
                    else if (refl_out_q && width_q <= WIDTH_16)
                    begin
                        lo16 = {<<{running_q[15:0]}};
                        want = crc_word_t'(lo16);
                    end
                    crc_queue.push_back(want);
                end
            end

            if (out_ch.valid && out_ch.ready)
            begin
                results_out++;
                if (crc_queue.size() == 0)
                    report($sformatf("crc_result %08h with no message pending",
                                     out_ch.crc_result));
                else
                begin
                    want = crc_queue.pop_front();
                    if (out_ch.crc_result !== want)
                        report($sformatf("crc_result %08h, predicted %08h",
                                         out_ch.crc_result, want));
                end
            end
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input crc_byte_t value, input logic is_first, input logic is_last);
        int unsigned gap;
        gap = gaps_on ? idle_len() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= value;
        in_ch.first_byte <= is_first;
        in_ch.last_byte  <= is_last;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(crc_byte_t'($urandom), i == 0, i == len - 1);
    endtask

    // drop valid, then hold until every result is in and the engine is quiet
    task automatic wait_for_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (crc_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input crc_word_t value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_settings(input crc_word_t init, input crc_word_t poly,
                                 input crc_width_t width, input logic ri, input logic ro);
        crc_word_t width_word;
        crc_word_t ri_word;
        crc_word_t ro_word;
        // junk above each narrow register must be dropped
        width_word = $urandom;
        width_word[WIDTH_BITS-1:0] = width;
        ri_word    = $urandom;
        ri_word[0] = ri;
        ro_word    = $urandom;
        ro_word[0] = ro;
        wait_for_idle();
        write_reg(CFG_INITIAL_VALUE, init);
        write_reg(CFG_POLYNOMIAL, poly);
        write_reg(CFG_CRC_WIDTH, width_word);
        write_reg(CFG_REFLECT_INPUT, ri_word);
        write_reg(CFG_REFLECT_OUTPUT, ro_word);
        if ($urandom_range(0, 3) == 0)
            write_reg(cfg_index_t'($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED)), $urandom);
        settings_done++;
    endtask

    task automatic test_reset_defaults();
        // no first byte after reset: folding starts from zero
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        send_byte(8'h31, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_width7_top_bit();
        load_settings(32'h0000_0000, 32'h0000_0009, WIDTH_7, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h7F, 1'b1, 1'b1);
    endtask

    task automatic test_reflection();
        load_settings(32'h0000_00FF, 32'h0000_0007, WIDTH_8, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b1);
        // unsupported widths still reflect 16 or 8 bits of the loaded value
        load_settings(32'hA5C3_1234, 32'h0000_1021, 6'd12, 1'b0, 1'b1);
        send_byte(8'h42, 1'b1, 1'b1);
        load_settings(32'h8001_00F1, 32'h0000_0007, '0, 1'b0, 1'b1);
        send_byte(8'h99, 1'b1, 1'b1);
    endtask

    task automatic test_unsupported_widths();
        load_settings('1, '1, '1, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b1, 1'b1);
        load_settings(32'h1234_5678, 32'h0000_8005, 6'd17, 1'b1, 1'b1);
        send_byte(8'hC3, 1'b1, 1'b1);
    endtask

    task automatic test_crc32();
        load_settings('1, 32'h04C1_1DB7, WIDTH_32, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h31, 1'b0, 1'b1);
    endtask

    task automatic test_unmapped_index();
        wait_for_idle();
        write_reg(FIRST_UNMAPPED, '1);
        write_reg(FIRST_UNMAPPED + 3'd1, '0);
        write_reg(LAST_UNMAPPED, 32'h5555_5555);
        send_byte(8'hA5, 1'b1, 1'b1);
    endtask

    task automatic test_write_mid_message();
        load_settings(32'h0000_FFFF, 32'h0000_1021, WIDTH_16, 1'b0, 1'b0);
        send_byte(8'h12, 1'b1, 1'b0);
        wait_for_idle();
        write_reg(CFG_POLYNOMIAL, 32'h0000_8005);
        write_reg(CFG_REFLECT_OUTPUT, 32'h0000_0001);
        send_byte(8'h34, 1'b0, 1'b1);
        // continue from the kept CRC without a first byte
        send_byte(8'h56, 1'b0, 1'b1);
    endtask

    task automatic test_random_settings();
        crc_width_t  widths[4];
        int unsigned sent;
        int unsigned n;
        widths = '{WIDTH_7, WIDTH_8, WIDTH_16, WIDTH_32};
        for (int ph = 0; ph < RANDOM_SETTINGS; ph++)
        begin
            case (ph)
                0: load_settings('0, '0, WIDTH_7, 1'b0, 1'b0);
                1: load_settings('1, '1, WIDTH_32, 1'b1, 1'b1);
                2: load_settings($urandom, $urandom, '1, 1'b0, 1'b1);
                3: load_settings($urandom, $urandom, '0, 1'b1, 1'b1);
                default: load_settings($urandom, $urandom, widths[ph % 4],
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < BYTES_PER_SETTING)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray bytes with arbitrary marks
                    n = $urandom_range(1, 3);
                    repeat (n) send_byte(crc_byte_t'($urandom), 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)));
                end
                else
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 8);
                    send_message(n);
                end
                sent += n;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin : result_sink
        int unsigned n;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (n) @(negedge clk) out_ch.ready <= 1'b1;
            n = idle_len();
            repeat (n) @(negedge clk) out_ch.ready <= 1'b0;
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        report("timed out waiting for the engine");
        $display("configurable_crc_engine: mismatch");
        $finish;
    end

    initial
    begin : run
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_width7_top_bit();
        test_reflection();
        test_unsupported_widths();
        test_crc32();
        test_unmapped_index();
        test_write_mid_message();
        test_random_settings();
        wait_for_idle();

        $display("Folded %0d bytes and checked %0d CRC results", bytes_in, results_out);
        $display("across %0d register settings, with unsupported and extreme widths",
                 settings_done);
        if (error_count == 0)
            $display("configurable_crc_engine: match");
        else
            $display("configurable_crc_engine: mismatch");
        $finish;
    end
endmodule
